// ===== hw/rtl/bds_pkg.sv =====
// Shared types, constants and register codes for the box downsample resolve.
// Used by every module in hw/rtl except bds_ram; no dependencies of its own.
package bds_pkg;

  localparam int DEF_MAX_TARGET_WIDTH = 1024;
  localparam int DEF_MAX_SCALE        = 8;
  localparam int MAX_TARGET_HEIGHT    = 4096;

  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int NUM_CH     = 3;
  localparam int SCALE_W    = 4;
  localparam int TWIDTH_W   = 11;
  localparam int THEIGHT_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [SCALE_W-1:0]   SCALE_RST  = 4'd2;
  localparam logic [TWIDTH_W-1:0]  TWIDTH_RST = 11'd640;
  localparam logic [THEIGHT_W-1:0] THEIGHT_RST = 13'd480;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BLOCK_SCALE   = 2'd0;
  localparam cfg_idx_t CFG_TARGET_WIDTH  = 2'd1;
  localparam cfg_idx_t CFG_TARGET_HEIGHT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_end;
  } res_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_PUT,
    S_SYNC,
    S_SWAIT
  } bds_state_t;

  typedef struct packed {
    logic take;       // capture pixel, read accumulator
    logic acc;        // write back block sum
    logic div_avg;    // start block average division
    logic div_sync;   // start line position division
    logic sync_load;  // load column counters from divider
    logic out_load;   // load result register
  } bds_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic div_busy;
  } bds_stat_t;

endpackage

// ===== hw/rtl/bds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module bds_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/bds_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on bds_pkg for the lane count.
module bds_div #(
  parameter int DVW = 14,
  parameter int AW  = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [bds_pkg::NUM_CH-1:0][DVW-1:0] dividend,
  input  logic [AW-1:0]                       divisor,
  output logic                                busy,
  output logic                                done,
  output logic [bds_pkg::NUM_CH-1:0][DVW-1:0] quotient,
  output logic [bds_pkg::NUM_CH-1:0][AW-1:0]  remainder
);
  import bds_pkg::*;

  localparam int CW = (DVW > 1) ? $clog2(DVW) : 1;

  logic [NUM_CH-1:0][DVW-1:0] work;
  logic [NUM_CH-1:0][AW-1:0]  rem_r;
  logic [AW-1:0]              d_r;
  logic [CW-1:0]              cnt;
  logic                       busy_r;
  logic                       done_r;
  logic [NUM_CH-1:0][AW:0]    trial;
  logic [NUM_CH-1:0][AW:0]    diff;
  logic [NUM_CH-1:0]          ge;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      trial[i] = {rem_r[i], work[i][DVW-1]};
      ge[i]    = trial[i] >= {1'b0, d_r};
      diff[i]  = trial[i] - {1'b0, d_r};
    end
  end

  // work holds the dividend bits still to come; quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      work  <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      for (int i = 0; i < NUM_CH; i++) begin
        rem_r[i] <= ge[i] ? diff[i][AW-1:0] : trial[i][AW-1:0];
        work[i]  <= {work[i][DVW-2:0], ge[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt    <= '0;
      end else if (busy_r) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = work;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/bds_datapath.sv =====
// Datapath: config registers, raster counters, accumulator line RAM,
// shared divider and result register. Depends on bds_pkg, bds_ram, bds_div.
module bds_datapath #(
  parameter int MAX_TARGET_WIDTH = bds_pkg::DEF_MAX_TARGET_WIDTH,
  parameter int MAX_SCALE        = bds_pkg::DEF_MAX_SCALE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  bds_pkg::cfg_idx_t               cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  bds_pkg::pix_item_t              pix_data,
  input  bds_pkg::bds_cmd_t               cmd,
  output bds_pkg::bds_stat_t              stat,
  output bds_pkg::res_item_t              res_data
);
  import bds_pkg::*;

  localparam int BXW  = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
  localparam int RCW  = (MAX_TARGET_WIDTH * MAX_SCALE > 1) ?
                        $clog2(MAX_TARGET_WIDTH * MAX_SCALE) : 1;
  localparam int RWW  = $clog2(MAX_TARGET_WIDTH * MAX_SCALE + 1);
  localparam int SW   = $clog2(MAX_SCALE + 1);
  localparam int SRW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int TWW  = $clog2(MAX_TARGET_WIDTH + 1);
  localparam int AW   = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int SUMW = $clog2(PIX_MAX * MAX_SCALE * MAX_SCALE + 1);
  localparam int DVW  = (SUMW > RCW) ? SUMW : RCW;

  // config registers
  logic [SCALE_W-1:0]   scale_reg;
  logic [TWIDTH_W-1:0]  width_reg;
  logic [THEIGHT_W-1:0] height_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_reg  <= SCALE_RST;
      width_reg  <= TWIDTH_RST;
      height_reg <= THEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BLOCK_SCALE:   scale_reg  <= cfg_data[SCALE_W-1:0];
        CFG_TARGET_WIDTH:  width_reg  <= cfg_data[TWIDTH_W-1:0];
        CFG_TARGET_HEIGHT: height_reg <= cfg_data[THEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [SW-1:0]        s_eff;
  logic [SW-1:0]        s_m1;
  logic [TWW-1:0]       tw_eff;
  logic [THEIGHT_W-1:0] th_eff;
  logic [RWW-1:0]       rw;
  logic [AW-1:0]        area;

  always_comb begin
    if (scale_reg == '0) begin
      s_eff = SW'(1);
    end else if (32'(scale_reg) > 32'(MAX_SCALE)) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_reg);
    end
    if (width_reg == '0) begin
      tw_eff = TWW'(1);
    end else if (32'(width_reg) > 32'(MAX_TARGET_WIDTH)) begin
      tw_eff = TWW'(MAX_TARGET_WIDTH);
    end else begin
      tw_eff = TWW'(width_reg);
    end
    if (height_reg == '0) begin
      th_eff = THEIGHT_W'(1);
    end else if (32'(height_reg) > 32'(MAX_TARGET_HEIGHT)) begin
      th_eff = THEIGHT_W'(MAX_TARGET_HEIGHT);
    end else begin
      th_eff = height_reg;
    end
  end

  assign s_m1 = s_eff - SW'(1);
  assign rw   = RWW'(RWW'(s_eff) * RWW'(tw_eff));
  assign area = AW'(AW'(s_eff) * AW'(s_eff));

  // raster counters; bx/sx track render_col / s and render_col % s
  logic [RCW-1:0]   render_col, render_col_next;
  logic [BXW-1:0]   bx, bx_next;
  logic [SRW-1:0]   sx, sx_next;
  logic [SRW-1:0]   sub_row, sub_row_next;
  logic [ROW_W-1:0] block_row, block_row_next;

  logic             rc_hit;
  logic [RCW-1:0]   rc_e;
  logic [BXW-1:0]   bx_e;
  logic [SRW-1:0]   sx_e;
  logic [SRW-1:0]   sr_e;
  logic [ROW_W-1:0] br_e;
  logic             first_e, last_e, fend_e;
  logic [RWW-1:0]   rc_inc;
  logic [SW-1:0]    sr_inc;
  logic [THEIGHT_W-1:0] br_inc;

  // counters beyond a shrunken bound restart at zero
  assign rc_hit  = RWW'(render_col) >= rw;
  assign rc_e    = rc_hit ? '0 : render_col;
  assign bx_e    = rc_hit ? '0 : bx;
  assign sx_e    = rc_hit ? '0 : sx;
  assign sr_e    = (SW'(sub_row) >= s_eff) ? '0 : sub_row;
  assign br_e    = (THEIGHT_W'(block_row) >= th_eff) ? '0 : block_row;
  assign first_e = (sr_e == '0) && (sx_e == '0);
  assign last_e  = (SW'(sr_e) == s_m1) && (SW'(sx_e) == s_m1);
  assign fend_e  = (TWW'(bx_e) == tw_eff - TWW'(1)) &&
                   (THEIGHT_W'(br_e) == th_eff - THEIGHT_W'(1));
  assign rc_inc  = RWW'(rc_e) + RWW'(1);
  assign sr_inc  = SW'(sr_e) + SW'(1);
  assign br_inc  = THEIGHT_W'(br_e) + THEIGHT_W'(1);

  // shared divider
  logic                       div_start;
  logic [NUM_CH-1:0][DVW-1:0] div_a;
  logic [AW-1:0]              div_d;
  logic                       div_busy, div_done;
  logic [NUM_CH-1:0][DVW-1:0] div_q;
  logic [NUM_CH-1:0][AW-1:0]  div_r;

  always_comb begin
    render_col_next = render_col;
    bx_next         = bx;
    sx_next         = sx;
    sub_row_next    = sub_row;
    block_row_next  = block_row;
    if (cmd.take) begin
      sub_row_next   = sr_e;
      block_row_next = br_e;
      if (rc_inc >= rw) begin
        render_col_next = '0;
        bx_next         = '0;
        sx_next         = '0;
        if (sr_inc >= s_eff) begin
          sub_row_next   = '0;
          block_row_next = (br_inc >= th_eff) ? '0 : br_inc[ROW_W-1:0];
        end else begin
          sub_row_next = sr_inc[SRW-1:0];
        end
      end else begin
        render_col_next = rc_inc[RCW-1:0];
        if (SW'(sx_e) == s_m1) begin
          sx_next = '0;
          bx_next = bx_e + BXW'(1);
        end else begin
          sx_next = sx_e + SRW'(1);
          bx_next = bx_e;
        end
      end
    end else if (cmd.sync_load) begin
      render_col_next = rc_e;
      bx_next         = div_q[0][BXW-1:0];
      sx_next         = div_r[0][SRW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      render_col <= '0;
      bx         <= '0;
      sx         <= '0;
      sub_row    <= '0;
      block_row  <= '0;
    end else begin
      render_col <= render_col_next;
      bx         <= bx_next;
      sx         <= sx_next;
      sub_row    <= sub_row_next;
      block_row  <= block_row_next;
    end
  end

  // item held across accumulate and divide
  pix_item_t        pix_q;
  logic             first_q, last_q, fend_q;
  logic [BXW-1:0]   bx_q;
  logic [ROW_W-1:0] row_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_q   <= pix_data;
      first_q <= first_e;
      last_q  <= last_e;
      fend_q  <= fend_e;
      bx_q    <= bx_e;
      row_q   <= br_e;
    end
  end

  // accumulator line
  logic [NUM_CH*SUMW-1:0]        rd_data;
  logic [NUM_CH*SUMW-1:0]        wr_data;
  logic [NUM_CH-1:0][PIX_W-1:0]  pix_ch;
  logic [NUM_CH-1:0][SUMW-1:0]   sum;

  assign pix_ch[0] = pix_q.red_in;
  assign pix_ch[1] = pix_q.green_in;
  assign pix_ch[2] = pix_q.blue_in;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (first_q) begin
        sum[c] = SUMW'(pix_ch[c]);
      end else begin
        sum[c] = SUMW'(rd_data[c*SUMW +: SUMW] + SUMW'(pix_ch[c]));
      end
      wr_data[c*SUMW +: SUMW] = sum[c];
    end
  end

  bds_ram #(
    .WIDTH(NUM_CH * SUMW),
    .DEPTH(MAX_TARGET_WIDTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (cmd.acc),
    .wr_addr(bx_q),
    .wr_data(wr_data),
    .rd_en  (cmd.take),
    .rd_addr(bx_e),
    .rd_data(rd_data)
  );

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd.div_sync) begin
        div_a[c] = (c == 0) ? DVW'(rc_e) : '0;
      end else begin
        div_a[c] = DVW'(sum[c]);
      end
    end
    div_d = cmd.div_sync ? AW'(s_eff) : area;
  end

  assign div_start = cmd.div_avg | cmd.div_sync;

  bds_div #(
    .DVW(DVW),
    .AW (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_r)
  );

  // result register
  logic [COL_W+BXW-1:0] col_ext;
  assign col_ext = {{COL_W{1'b0}}, bx_q};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_data.red_out   <= div_q[0][PIX_W-1:0];
      res_data.green_out <= div_q[1][PIX_W-1:0];
      res_data.blue_out  <= div_q[2][PIX_W-1:0];
      res_data.out_col   <= col_ext[COL_W-1:0];
      res_data.out_row   <= row_q;
      res_data.frame_end <= fend_q;
    end
  end

  assign stat.emit     = last_q;
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;

endmodule

// ===== hw/rtl/bds_ctrl.sv =====
// Controller state machine: sequences read, accumulate, divide and result
// hand-off, and the counter resync after a register write. Depends on bds_pkg.
module bds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               pix_valid,
  output logic               pix_ready,
  output logic               res_valid,
  input  logic               res_ready,
  input  bds_pkg::bds_stat_t stat,
  output bds_pkg::bds_cmd_t  cmd
);
  import bds_pkg::*;

  bds_state_t state, state_next;
  logic       pend;
  logic       res_free;

  assign res_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pend) begin
          state_next = S_SYNC;
        end else if (pix_valid) begin
          state_next = S_ACC;
        end
      end
      S_ACC:   state_next = stat.emit ? S_DIV : S_IDLE;
      S_DIV:   if (stat.div_done) state_next = S_PUT;
      S_PUT:   if (res_free) state_next = S_IDLE;
      S_SYNC:  state_next = S_SWAIT;
      S_SWAIT: if (stat.div_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    pix_ready = 1'b0;
    case (state)
      S_IDLE: begin
        pix_ready = !pend;
        cmd.take  = !pend && pix_valid;
      end
      S_ACC: begin
        cmd.acc     = 1'b1;
        cmd.div_avg = stat.emit;
      end
      S_DIV: ;
      S_PUT:   cmd.out_load  = res_free;
      S_SYNC:  cmd.div_sync  = 1'b1;
      S_SWAIT: cmd.sync_load = stat.div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a write during the sync start still leaves a resync pending
      if (cfg_write) begin
        pend <= 1'b1;
      end else if (state == S_SYNC) begin
        pend <= 1'b0;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/box_downsample_ssaa_unit.sv =====
// Box-filter downsample resolve. A pixel that does not close a block is read from the
// accumulator, then written back; a pixel that closes a block also runs the bit-serial
// divider (one quotient bit per cycle, 14 bits by default). Its result is loaded once
// the divider is done and the result register is free; no pixel is taken until then.
// A register write triggers a counter resync on the same divider; no pixel is taken
// meanwhile. Reset: counters zero, registers 2/640/480, line RAM not cleared.
module box_downsample_ssaa_unit #(
  parameter int MAX_TARGET_WIDTH = bds_pkg::DEF_MAX_TARGET_WIDTH,
  parameter int MAX_SCALE        = bds_pkg::DEF_MAX_SCALE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  bds_pkg::cfg_idx_t              cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  bds_pkg::pix_item_t             pix_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output bds_pkg::res_item_t             res_data
);
  import bds_pkg::*;

  bds_cmd_t  cmd;
  bds_stat_t stat;
  logic      cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  bds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bds_datapath #(
    .MAX_TARGET_WIDTH(MAX_TARGET_WIDTH),
    .MAX_SCALE       (MAX_SCALE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_data (pix_data),
    .cmd      (cmd),
    .stat     (stat),
    .res_data (res_data)
  );

  a_take_then_acc: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_ready) |=> cmd.acc)
    else $error("accepted item not accumulated next cycle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!res_valid || res_ready))
    else $error("result register overwritten while full");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_avg || cmd.div_sync) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !pix_ready)
    else $error("item accepted while divider busy");

endmodule

// ===== dv/tb_box_downsample_ssaa_unit.sv =====
`timescale 1ns / 100ps
// Testbench for box_downsample_ssaa_unit: streams render pixels and register writes,
// predicts each averaged output pixel and checks results in order.
// Depends on bds_pkg and the RTL only.
module tb_box_downsample_ssaa_unit;
  import bds_pkg::*;

  // Tracks the resolve state and holds the averaged pixels still to come out.
  class resolve_sb;
    int unsigned scale_reg, width_reg, height_reg;
    int unsigned col, sub, brow;
    logic [13:0] sums [DEF_MAX_TARGET_WIDTH][NUM_CH];
    bit touched [DEF_MAX_TARGET_WIDTH];
    res_item_t pending_avgs [$];
    int unsigned errors;

    function new();
      scale_reg  = SCALE_RST;
      width_reg  = TWIDTH_RST;
      height_reg = THEIGHT_RST;
      col = 0;
      sub = 0;
      brow = 0;
      errors = 0;
    endfunction

    function int unsigned clamp_to(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function void eff(output int unsigned s, output int unsigned tw, output int unsigned th);
      s  = clamp_to(scale_reg, DEF_MAX_SCALE);
      tw = clamp_to(width_reg, DEF_MAX_TARGET_WIDTH);
      th = clamp_to(height_reg, MAX_TARGET_HEIGHT);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_BLOCK_SCALE:   scale_reg = val[SCALE_W-1:0];
        CFG_TARGET_WIDTH:  width_reg = val[TWIDTH_W-1:0];
        CFG_TARGET_HEIGHT: height_reg = val[THEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // True when switching to this scale/width now cannot make the block read
    // an accumulator entry that was never written.
    function bit safe_switch(int unsigned s_raw, int unsigned w_raw);
      int unsigned s, tw, c, r, first;
      s  = clamp_to(s_raw, DEF_MAX_SCALE);
      tw = clamp_to(w_raw, DEF_MAX_TARGET_WIDTH);
      if (s == 1) return 1;
      c = (col >= tw * s) ? 0 : col;
      r = (sub >= s) ? 0 : sub;
      // in the top line of a block row, columns from c on start fresh
      first = (r == 0) ? (c + s - 1) / s : tw;
      for (int i = 0; i < first; i++)
        if (!touched[i]) return 0;
      return 1;
    endfunction

    function void note_pixel(pix_item_t p);
      int unsigned s, tw, th, bx, sx, area;
      logic [PIX_W-1:0] ch [NUM_CH];
      res_item_t r;
      eff(s, tw, th);
      ch[0] = p.red_in;
      ch[1] = p.green_in;
      ch[2] = p.blue_in;
      if (col >= tw * s) col = 0;
      if (sub >= s) sub = 0;
      if (brow >= th) brow = 0;
      bx = col / s;
      sx = col % s;
      for (int c = 0; c < NUM_CH; c++) begin
        if (sub == 0 && sx == 0) sums[bx][c] = ch[c];
        else sums[bx][c] = sums[bx][c] + ch[c];  // wraps at 14 bits
      end
      touched[bx] = 1;
      if (sub == s - 1 && sx == s - 1) begin
        area = s * s;
        r.red_out   = 8'(sums[bx][0] / area);
        r.green_out = 8'(sums[bx][1] / area);
        r.blue_out  = 8'(sums[bx][2] / area);
        r.out_col   = 10'(bx);
        r.out_row   = 12'(brow);
        r.frame_end = (bx == tw - 1 && brow == th - 1);
        pending_avgs.insert(pending_avgs.size(), r);
      end
      col++;
      if (col >= tw * s) begin
        col = 0;
        sub++;
        if (sub >= s) begin
          sub = 0;
          brow++;
          if (brow >= th) brow = 0;
        end
      end
    endfunction

    function void flag(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (pending_avgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected averaged pixel col %0d row %0d", $time,
                 got.out_col, got.out_row);
        return;
      end
      want = pending_avgs.pop_front();
      if (got.red_out !== want.red_out) flag("red_out", want.red_out, got.red_out);
      if (got.green_out !== want.green_out) flag("green_out", want.green_out, got.green_out);
      if (got.blue_out !== want.blue_out) flag("blue_out", want.blue_out, got.blue_out);
      if (got.out_col !== want.out_col) flag("out_col", want.out_col, got.out_col);
      if (got.out_row !== want.out_row) flag("out_row", want.out_row, got.out_row);
      if (got.frame_end !== want.frame_end) flag("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic pix_valid, pix_ready;
  pix_item_t pix_data;
  logic res_valid, res_ready;
  res_item_t res_data;

  int snd_idle, rcv_idle, rcv_hold;
  resolve_sb sb = new();

  box_downsample_ssaa_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always #2 clk = ~clk;

  // Result side: random back-pressure plus long hold-offs on request.
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold > 0) begin
        rcv_hold--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res_data);
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, PIX_MAX));
    endcase
  endfunction

  function automatic pix_item_t rand_pixel();
    return '{rand_chan(), rand_chan(), rand_chan()};
  endfunction

  task automatic put_pixel(pix_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= item;
    do @(posedge clk); while (!pix_ready);
    sb.note_pixel(item);
  endtask

  task automatic stop_pixels();
    @(negedge clk);
    pix_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_avgs.size() != 0) @(posedge clk);
    // a pixel that closes no block may still be in flight
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(int unsigned s, int unsigned w, int unsigned h);
    stop_pixels();
    drain();
    if (!sb.safe_switch(s, w)) s = 1;  // scale 1 never reads old sums
    write_reg(CFG_BLOCK_SCALE, CFG_DATA_W'(s));
    write_reg(CFG_TARGET_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_TARGET_HEIGHT, CFG_DATA_W'(h));
  endtask

  initial begin
    int unsigned sent, phase, fsz, len, s, w, h;
    pix_item_t px;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BLOCK_SCALE;
    cfg_data = '0;
    snd_idle = 31;
    rcv_idle = 74;
    rcv_hold = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, then a change partway through the first line
    for (int k = 0; k < 2; k++) put_pixel(rand_pixel());
    reconfigure(2, 2, 2);
    for (int k = 0; k < 16; k++) begin
      px.red_in   = k[2] ? '1 : '0;
      px.green_in = k[2] ? '1 : '0;
      px.blue_in  = k[0] ? '1 : '0;
      put_pixel(px);
    end
    // zero registers act as 1: every pixel is a whole frame
    reconfigure(0, 0, 0);
    put_pixel('{'0, '0, '0});
    put_pixel('{'1, '1, '1});
    put_pixel(rand_pixel());
    // values above the maximum clamp
    reconfigure(15, 2047, 8191);
    for (int k = 0; k < 4; k++) put_pixel(rand_pixel());

    // one full row at maximum width touches every accumulator entry
    reconfigure(1, 1024, 1);
    for (int k = 0; k < 1024; k++) put_pixel(rand_pixel());

    // items sent so far count toward the total
    sent = 2 + 16 + 3 + 4 + 1024;
    phase = 0;
    while (sent < 1600) begin
      if (sent >= 1425) begin
        snd_idle = 0;
        rcv_idle = 0;
      end else if (sent >= 1250) begin
        snd_idle = 74;
        rcv_idle = 31;
      end
      if (phase % 7 == 3) begin
        // every pixel closes a block while the output is held off
        reconfigure(1, $urandom_range(1, 6), $urandom_range(1, 4));
        rcv_hold = $urandom_range(150, 300);
        len = 60;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            if ($urandom_range(0, 6) == 0) begin
              case ($urandom_range(0, 4))
                0: s = 0;
                1: s = 8;
                2: s = 15;
                default: s = $urandom_range(0, 15);
              endcase
              case ($urandom_range(0, 4))
                0: w = 0;
                1: w = 1024;
                2: w = 2047;
                default: w = $urandom_range(0, 2047);
              endcase
              case ($urandom_range(0, 4))
                0: h = 0;
                1: h = 4096;
                2: h = 8191;
                default: h = $urandom_range(0, 8191);
              endcase
            end else begin
              s = $urandom_range(1, 4);
              w = $urandom_range(1, 6);
              h = $urandom_range(1, 4);
            end
            reconfigure(s, w, h);
          end
          1: begin
            stop_pixels();
            drain();
          end
          default: ;
        endcase
        sb.eff(s, w, h);
        fsz = s * s * w * h;
        len = (fsz <= 60) ? fsz * $urandom_range(1, 2) : $urandom_range(10, 60);
        if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 7);
      end
      for (int k = 0; k < len; k++) put_pixel(rand_pixel());
      sent += len;
      phase++;
    end

    stop_pixels();
    for (int k = 0; k < 20000 && sb.pending_avgs.size() != 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.pending_avgs.size() != 0)
      $display("%0t: %0d averaged pixels never came out", $time, sb.pending_avgs.size());
    if (sb.errors == 0 && sb.pending_avgs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== box_downsample_ssaa_unit.f =====
hw/rtl/bds_pkg.sv
hw/rtl/bds_ram.sv
hw/rtl/bds_div.sv
hw/rtl/bds_datapath.sv
hw/rtl/bds_ctrl.sv
hw/rtl/box_downsample_ssaa_unit.sv
dv/tb_box_downsample_ssaa_unit.sv
